[rtl/frc_pkg.sv]
// Shared types, constants and CRC helper for the fragment reassembler.
// No dependencies; imported by frc_crc and the top level of the block.
package frc_pkg;

  localparam int HEADER_BYTES          = 12;
  localparam int PREFIX_BYTES          = 5;
  localparam int TRAILER_BYTES         = 4;
  localparam int PACKET_MAX_BYTES_DEF  = 256;
  localparam int BODY_MAX_BYTES_DEF    = 1024;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

  localparam logic [7:0]  COMMAND_CODE_RST = 8'd0;
  localparam logic [7:0]  VERSION_RST      = 8'd1;
  localparam logic [7:0]  MAX_DIR_RST      = 8'd2;
  localparam logic [31:0] TIMEOUT_RST      = 32'd1000;

  typedef enum logic [1:0] {
    REG_COMMAND = 2'd0,
    REG_VERSION = 2'd1,
    REG_MAX_DIR = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_MSG  = 2'd1,
    ST_BAD  = 2'd2,
    ST_READ = 2'd3
  } status_t;

  typedef struct packed {
    logic       init;
    logic       feed;
    logic [7:0] data;
  } crc_ctl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[rtl/frc_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
// Depends on nothing but its parameters.
module frc_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/frc_crc.sv]
// Byte-wide CRC-32 accumulator shared by the prefix and body passes.
// Depends on frc_pkg (crc_ctl_t, crc_byte, CRC_INIT).
module frc_crc
  import frc_pkg::*;
(
  input  logic        clk,
  input  crc_ctl_t    ctl,
  output logic [31:0] crc
);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_INIT;
    end else if (ctl.feed) begin
      crc <= crc_byte(crc, ctl.data);
    end
  end

endmodule

[rtl/fragment_reassembler_crc_check_unit.sv]
// Fragment reassembler with CRC-32 check: top level, sequencer and state.
// Depends on frc_pkg, frc_ram (packet stage, body store) and frc_crc.
// A packet byte that is not last is accepted and leaves busy low. A last byte holds busy
// through the epoch check, header fetch and header checks, then while the fragment is
// compared or merged, and through the prefix and body CRC passes when it completes a
// message; a short or overlong packet returns to idle from the epoch check. A read holds
// busy for the S_RD state. done pulses in the cycle busy drops; the receiver cannot stall.
// rst (synchronous) clears control state; RAM contents are undefined until written.
module fragment_reassembler_crc_check_unit
  import frc_pkg::*;
#(
  parameter int PACKET_MAX_BYTES = PACKET_MAX_BYTES_DEF,
  parameter int BODY_MAX_BYTES   = BODY_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] link_epoch,
  input  logic [31:0] time_ms,
  input  logic [9:0]  read_index,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] msg_id,
  output logic [7:0]  message_kind,
  output logic [7:0]  message_direction,
  output logic [9:0]  payload_length,
  output logic [7:0]  read_data
);

  localparam int SAW = $clog2(PACKET_MAX_BYTES);
  localparam int PCW = $clog2(PACKET_MAX_BYTES + 1);
  localparam int BAW = $clog2(BODY_MAX_BYTES);
  localparam int BCW = $clog2(BODY_MAX_BYTES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_EPOCH = 10'b00_0000_0010,
    S_HDR   = 10'b00_0000_0100,
    S_CHECK = 10'b00_0000_1000,
    S_CMP   = 10'b00_0001_0000,
    S_APP   = 10'b00_0010_0000,
    S_PREF  = 10'b00_0100_0000,
    S_CRCW  = 10'b00_1000_0000,
    S_CRCCK = 10'b01_0000_0000,
    S_RD    = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [7:0]  command_code, protocol_version, max_direction;
  logic [31:0] assembly_timeout_ms;

  // Assembly state.
  logic           assembly_active;
  logic [31:0]    stored_epoch, start_time;
  logic [15:0]    current_id;
  logic [7:0]     current_kind, current_direction;
  logic [BCW-1:0] expected_total, bytes_received;
  logic [PCW-1:0] packet_count;
  logic           packet_overflow;

  // Per-packet working registers.
  logic [31:0]    epoch_r, now_r;
  logic [7:0]     hdr [HEADER_BYTES];
  logic [BCW-1:0] k;
  logic [BCW-1:0] ofs_r, cnt_r;
  logic           eq_r;
  logic [31:0]    want;
  logic           rd_in_range;

  // RAM ports.
  logic           stage_we;
  logic [SAW-1:0] stage_waddr, stage_raddr;
  logic [7:0]     stage_rdata;
  logic           body_we;
  logic [BAW-1:0] body_waddr, body_raddr;
  logic [7:0]     body_rdata;

  crc_ctl_t       crc_ctl;
  logic [31:0]    crc;

  logic accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  frc_ram #(.DEPTH(PACKET_MAX_BYTES), .AW(SAW)) u_stage (
    .clk(clk), .we(stage_we), .waddr(stage_waddr), .wdata(data_byte),
    .raddr(stage_raddr), .rdata(stage_rdata)
  );

  frc_ram #(.DEPTH(BODY_MAX_BYTES), .AW(BAW)) u_body (
    .clk(clk), .we(body_we), .waddr(body_waddr), .wdata(stage_rdata),
    .raddr(body_raddr), .rdata(body_rdata)
  );

  frc_crc u_crc (.clk(clk), .ctl(crc_ctl), .crc(crc));

  // Header fields, decoded from the captured header bytes.
  logic [15:0] h_id, h_ofs, h_tot, cnt16, br_eff;
  logic        bad_hdr, bad_bnd, match;
  assign h_id   = {hdr[7], hdr[6]};
  assign h_ofs  = {hdr[9], hdr[8]};
  assign h_tot  = {hdr[11], hdr[10]};
  assign cnt16  = 16'(packet_count) - 16'(HEADER_BYTES);
  assign bad_hdr = (hdr[0] != 8'd0) || (hdr[2] != command_code) ||
                   (hdr[4] != protocol_version) || (hdr[5] > max_direction) ||
                   (hdr[1] != hdr[6]);
  assign bad_bnd = (h_tot < 16'(TRAILER_BYTES)) || (h_tot > 16'(BODY_MAX_BYTES)) ||
                   (h_ofs >= h_tot) || (cnt16 > (h_tot - h_ofs));
  assign match  = assembly_active && (current_id == h_id) && (current_kind == hdr[3]) &&
                  (current_direction == hdr[5]) && (16'(expected_total) == h_tot);
  assign br_eff = match ? 16'(bytes_received) : 16'd0;

  // Stage writes happen on the accepting edge of every packet byte that still fits.
  assign stage_we    = accept && !op && (packet_count < PCW'(PACKET_MAX_BYTES));
  assign stage_waddr = SAW'(packet_count);

  // Read addresses: one byte per cycle, data back in the cycle after.
  always_comb begin
    stage_raddr = SAW'(k);
    body_raddr  = BAW'(read_index);
    case (state)
      S_CMP: begin
        stage_raddr = SAW'(k + BCW'(HEADER_BYTES));
        body_raddr  = BAW'(ofs_r + k);
      end
      S_APP:   stage_raddr = SAW'(k + BCW'(HEADER_BYTES));
      S_CRCW:  body_raddr  = BAW'(k);
      default: ;
    endcase
  end

  // Append: write the byte fetched for the previous index.
  assign body_we    = (state == S_APP) && (k != '0);
  assign body_waddr = BAW'(ofs_r + k - 1'b1);

  logic eq_now;
  assign eq_now = eq_r && ((k == '0) || (body_rdata == stage_rdata));

  logic [BCW-1:0] k_prev;
  assign k_prev = k - 1'b1;

  // CRC feed: prefix bytes, then payload bytes; trailer bytes go to want instead.
  always_comb begin
    crc_ctl = '0;
    case (state)
      S_APP: crc_ctl.init = (k == cnt_r);
      S_PREF: begin
        crc_ctl.feed = 1'b1;
        case (k[2:0])
          3'd0:    crc_ctl.data = protocol_version;
          3'd1:    crc_ctl.data = current_kind;
          3'd2:    crc_ctl.data = current_direction;
          3'd3:    crc_ctl.data = current_id[7:0];
          default: crc_ctl.data = current_id[15:8];
        endcase
      end
      S_CRCW: begin
        crc_ctl.feed = (k != '0) && (k_prev < (expected_total - BCW'(TRAILER_BYTES)));
        crc_ctl.data = body_rdata;
      end
      default: ;
    endcase
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      command_code        <= COMMAND_CODE_RST;
      protocol_version    <= VERSION_RST;
      max_direction       <= MAX_DIR_RST;
      assembly_timeout_ms <= TIMEOUT_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_COMMAND: command_code        <= cfg_data[7:0];
        REG_VERSION: protocol_version    <= cfg_data[7:0];
        REG_MAX_DIR: max_direction       <= cfg_data[7:0];
        REG_TIMEOUT: assembly_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      epoch_r     <= link_epoch;
      now_r       <= time_ms;
      rd_in_range <= (32'(read_index) < 32'(BODY_MAX_BYTES));
    end
    if (state == S_HDR && k != '0) begin
      hdr[4'(k_prev)] <= stage_rdata;
    end
    if (state == S_CRCW && k != '0 && !crc_ctl.feed) begin
      want <= {body_rdata, want[31:8]};
    end
  end

  // Sequencer and assembly state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      assembly_active   <= 1'b0;
      stored_epoch      <= '0;
      start_time        <= '0;
      current_id        <= '0;
      current_kind      <= '0;
      current_direction <= '0;
      expected_total    <= '0;
      bytes_received    <= '0;
      packet_count      <= '0;
      packet_overflow   <= 1'b0;
      k                 <= '0;
      ofs_r             <= '0;
      cnt_r             <= '0;
      eq_r              <= 1'b0;
      done              <= 1'b0;
      status            <= ST_MORE;
      msg_id            <= '0;
      message_kind      <= '0;
      message_direction <= '0;
      payload_length    <= '0;
      read_data         <= '0;
    end else begin
      done              <= 1'b0;
      status            <= ST_MORE;
      msg_id            <= '0;
      message_kind      <= '0;
      message_direction <= '0;
      payload_length    <= '0;
      read_data         <= '0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op) begin
              state <= S_RD;
            end else begin
              // Stage the byte, or mark the packet as too long.
              if (stage_we) begin
                packet_count <= packet_count + 1'b1;
              end else begin
                packet_overflow <= 1'b1;
              end
              if (last_byte) begin
                state <= S_EPOCH;
              end
            end
          end
        end
        S_RD: begin
          done      <= 1'b1;
          status    <= ST_READ;
          read_data <= rd_in_range ? body_rdata : 8'd0;
          state     <= S_IDLE;
        end
        S_EPOCH: begin
          // Drop a stale or timed-out assembly before looking at the header.
          if ((stored_epoch != epoch_r) ||
              (assembly_active && ((now_r - start_time) >= assembly_timeout_ms))) begin
            assembly_active <= 1'b0;
            stored_epoch    <= epoch_r;
          end
          if (packet_overflow || (packet_count <= PCW'(HEADER_BYTES))) begin
            done            <= 1'b1;
            status          <= ST_BAD;
            packet_count    <= '0;
            packet_overflow <= 1'b0;
            state           <= S_IDLE;
          end else begin
            k     <= '0;
            state <= S_HDR;
          end
        end
        S_HDR: begin
          if (k == BCW'(HEADER_BYTES)) begin
            state <= S_CHECK;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_CHECK: begin
          k     <= '0;
          eq_r  <= 1'b1;
          ofs_r <= BCW'(h_ofs);
          cnt_r <= BCW'(cnt16);
          if (bad_hdr || bad_bnd || (!match && (h_ofs != 16'd0))) begin
            done            <= 1'b1;
            status          <= ST_BAD;
            packet_count    <= '0;
            packet_overflow <= 1'b0;
            state           <= S_IDLE;
          end else begin
            if (!match) begin
              // Open a new assembly.
              assembly_active   <= 1'b1;
              start_time        <= now_r;
              current_id        <= h_id;
              current_kind      <= hdr[3];
              current_direction <= hdr[5];
              expected_total    <= BCW'(h_tot);
              bytes_received    <= '0;
            end
            if (h_ofs < br_eff) begin
              if (cnt16 <= (br_eff - h_ofs)) begin
                state <= S_CMP;
              end else begin
                assembly_active <= 1'b0;
                done            <= 1'b1;
                status          <= ST_BAD;
                packet_count    <= '0;
                packet_overflow <= 1'b0;
                state           <= S_IDLE;
              end
            end else if (h_ofs != br_eff) begin
              assembly_active <= 1'b0;
              done            <= 1'b1;
              status          <= ST_BAD;
              packet_count    <= '0;
              packet_overflow <= 1'b0;
              state           <= S_IDLE;
            end else begin
              state <= S_APP;
            end
          end
        end
        S_CMP: begin
          // Retransmitted overlap: must match stored bytes exactly.
          eq_r <= eq_now;
          if (k == cnt_r) begin
            if (!eq_now) begin
              assembly_active <= 1'b0;
            end
            done            <= 1'b1;
            status          <= eq_now ? ST_MORE : ST_BAD;
            packet_count    <= '0;
            packet_overflow <= 1'b0;
            state           <= S_IDLE;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_APP: begin
          if (k == cnt_r) begin
            bytes_received <= bytes_received + cnt_r;
            k              <= '0;
            if ((bytes_received + cnt_r) < expected_total) begin
              done            <= 1'b1;
              status          <= ST_MORE;
              packet_count    <= '0;
              packet_overflow <= 1'b0;
              state           <= S_IDLE;
            end else begin
              assembly_active <= 1'b0;
              state           <= S_PREF;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_PREF: begin
          if (k == BCW'(PREFIX_BYTES - 1)) begin
            k     <= '0;
            state <= S_CRCW;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_CRCW: begin
          if (k == expected_total) begin
            state <= S_CRCCK;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_CRCCK: begin
          done            <= 1'b1;
          packet_count    <= '0;
          packet_overflow <= 1'b0;
          state           <= S_IDLE;
          if ((crc ^ CRC_XOROUT) == want) begin
            status            <= ST_MSG;
            msg_id            <= current_id;
            message_kind      <= current_kind;
            message_direction <= current_direction;
            payload_length    <= 10'(expected_total - BCW'(TRAILER_BYTES));
          end else begin
            status <= ST_BAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result transaction always returns the sequencer to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while sequencer busy");

  // An open assembly never holds a complete body.
  a_active_partial: assert property (@(posedge clk) disable iff (rst)
    assembly_active |-> (bytes_received < expected_total))
    else $error("active assembly already complete");

  // Message fields stay zero unless a message completes.
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_MSG)) |-> ((msg_id == '0) && (payload_length == '0)))
    else $error("message fields set on non-message result");

  // Every last byte leaves the stage empty for the next packet.
  a_stage_cleared: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_READ)) |-> ((packet_count == '0) && !packet_overflow))
    else $error("packet stage not cleared after result");

endmodule
